// File: rtl/stpr_pkg.sv
// ----------------------------------------------------------------------------
// stpr_pkg
// Shared constants, word types and register codes for the trapezoid ramp
// step pulser.
// ----------------------------------------------------------------------------
package stpr_pkg;

  localparam int STEP_COUNT_BITS = 16;
  localparam int PERIOD_BITS     = 16;

  localparam int STEP_TOTAL_W = 16;
  localparam int HALF_W       = 16;
  localparam int RAMP_W       = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int WIDE_W       = 33;

  localparam logic [WIDE_W-1:0] COUNT_MAX  = (WIDE_W'(1) << STEP_COUNT_BITS) - WIDE_W'(1);
  localparam logic [WIDE_W-1:0] PERIOD_MAX = (WIDE_W'(1) << PERIOD_BITS) - WIDE_W'(1);

  localparam logic [HALF_W-1:0] START_HALF_RST = 16'd2000;
  localparam logic [HALF_W-1:0] MIN_HALF_RST   = 16'd500;
  localparam logic [RAMP_W-1:0] RAMP_INC_RST   = 8'd5;

  localparam int ACCEL_SHIFT = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_HALF = 2'd0,
    CFG_MIN_HALF   = 2'd1,
    CFG_RAMP_INC   = 2'd2
  } cfg_index_t;

  typedef enum logic {
    FUNC_TICK  = 1'b0,
    FUNC_START = 1'b1
  } func_t;

  typedef struct packed {
    logic                    func;
    logic [STEP_TOTAL_W-1:0] step_total;
  } in_word_t;

  typedef struct packed {
    logic step_level;
    logic busy_res;
    logic move_done;
  } out_word_t;

  typedef struct packed {
    logic [HALF_W-1:0] start_half_period;
    logic [HALF_W-1:0] min_half_period;
    logic [RAMP_W-1:0] ramp_increment;
  } cfg_t;

endpackage

// File: rtl/stepper_trapezoid_ramp_pulser.sv
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_pulser
// Step pulse generator with a trapezoidal speed profile.
//
// Each input word is either a start command carrying the step count or one
// time tick. Every input word yields exactly one result word: the step pin
// level, the busy flag and a move-done flag on the word ending the move.
// The result is valid in the cycle after input accept; one word is taken
// per cycle, set by the single result register behind the update logic.
// A new word is taken while a result is pending as long as the receiver
// does not stall; when out_stall holds the pending result, in_stall rises
// and the input side waits. Reset clears the move state, sets the
// half-period to the start value and loads the register defaults
// (start 2000, minimum 500, ramp 5). The configuration port is always
// ready; write it only while no move word is in flight.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp_pulser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  stpr_pkg::in_word_t               in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output stpr_pkg::out_word_t              out_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [stpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stpr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  stpr_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  stpr_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  stpr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// File: rtl/stpr_cfg_regs.sv
// ----------------------------------------------------------------------------
// stpr_cfg_regs
// Configuration register file: start and minimum half-period, ramp step.
// ----------------------------------------------------------------------------
module stpr_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [stpr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stpr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output stpr_pkg::cfg_t                      cfg_o
);

  stpr_pkg::cfg_t cfg_r;
  stpr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        stpr_pkg::CFG_START_HALF: cfg_nxt.start_half_period = cfg_data;
        stpr_pkg::CFG_MIN_HALF:   cfg_nxt.min_half_period   = cfg_data;
        stpr_pkg::CFG_RAMP_INC:   cfg_nxt.ramp_increment    =
                                    cfg_data[stpr_pkg::RAMP_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_half_period <= stpr_pkg::START_HALF_RST;
      cfg_r.min_half_period   <= stpr_pkg::MIN_HALF_RST;
      cfg_r.ramp_increment    <= stpr_pkg::RAMP_INC_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// File: rtl/stpr_core.sv
// ----------------------------------------------------------------------------
// stpr_core
// Move state, per-word pulse timing and ramp update, with the result register.
// ----------------------------------------------------------------------------
module stpr_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stpr_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  stpr_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output stpr_pkg::out_word_t  out_word
);

  localparam int SCB = stpr_pkg::STEP_COUNT_BITS;
  localparam int PB  = stpr_pkg::PERIOD_BITS;
  localparam int WW  = stpr_pkg::WIDE_W;
  localparam logic [PB-1:0] HALF_RST =
    (WW'(stpr_pkg::START_HALF_RST) > stpr_pkg::PERIOD_MAX) ?
      PB'(stpr_pkg::PERIOD_MAX) : PB'(stpr_pkg::START_HALF_RST);

  logic           running_r,   running_nxt;
  logic           pulse_r,     pulse_nxt;
  logic [SCB-1:0] step_r,      step_nxt;
  logic [SCB-1:0] length_r,    length_nxt;
  logic [PB-1:0]  half_r,      half_nxt;
  logic [PB-1:0]  phase_r,     phase_nxt;
  logic           out_valid_r, out_valid_nxt;
  stpr_pkg::out_word_t out_word_r, out_word_nxt;

  logic           accept;
  logic           done;
  logic [SCB-1:0] n_sat;
  logic [PB-1:0]  start_sat;
  logic [SCB-1:0] accel;
  logic [SCB-1:0] step_inc;
  logic [PB-1:0]  phase_inc;
  logic [WW-1:0]  half_w;
  logic [WW-1:0]  inc_w;
  logic [WW-1:0]  sum_w;
  logic [PB-1:0]  half_dec;
  logic [PB-1:0]  half_up;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    n_sat = (WW'(in_word.step_total) > stpr_pkg::COUNT_MAX) ?
              SCB'(stpr_pkg::COUNT_MAX) : SCB'(in_word.step_total);
    start_sat = (WW'(cfg.start_half_period) > stpr_pkg::PERIOD_MAX) ?
                  PB'(stpr_pkg::PERIOD_MAX) : PB'(cfg.start_half_period);
    accel     = length_r >> stpr_pkg::ACCEL_SHIFT;
    step_inc  = step_r + SCB'(1);
    phase_inc = phase_r + PB'(1);
    half_w    = WW'(half_r);
    inc_w     = WW'(cfg.ramp_increment);
    sum_w     = half_w + inc_w;
    half_dec  = (half_w > inc_w + WW'(1)) ? PB'(half_w - inc_w) : PB'(1);
    half_up   = (sum_w > stpr_pkg::PERIOD_MAX) ? PB'(stpr_pkg::PERIOD_MAX) : PB'(sum_w);

    running_nxt = running_r;
    pulse_nxt   = pulse_r;
    step_nxt    = step_r;
    length_nxt  = length_r;
    half_nxt    = half_r;
    phase_nxt   = phase_r;
    done        = 1'b0;

    if (in_word.func == stpr_pkg::FUNC_START) begin
      if (!running_r) begin
        if (n_sat == '0) begin
          pulse_nxt = 1'b0;
          done      = 1'b1;
        end else begin
          running_nxt = 1'b1;
          pulse_nxt   = 1'b1;
          phase_nxt   = '0;
          step_nxt    = '0;
          length_nxt  = n_sat;
          half_nxt    = start_sat;
        end
      end
    end else if (running_r) begin
      phase_nxt = phase_inc;
      if (phase_inc >= half_r) begin
        phase_nxt = '0;
        if (pulse_r) begin
          pulse_nxt = 1'b0;
        end else begin
          if (step_r < accel && half_w > WW'(cfg.min_half_period)) begin
            half_nxt = half_dec;
          end else if (step_r > length_r - accel &&
                       half_w < WW'(cfg.start_half_period)) begin
            half_nxt = half_up;
          end
          step_nxt = step_inc;
          if (step_inc >= length_r) begin
            running_nxt = 1'b0;
            done        = 1'b1;
          end else begin
            pulse_nxt = 1'b1;
          end
        end
      end
    end

    out_word_nxt.step_level = pulse_nxt;
    out_word_nxt.busy_res   = running_nxt;
    out_word_nxt.move_done  = done;

    out_valid_nxt = accept || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      pulse_r     <= 1'b0;
      step_r      <= '0;
      length_r    <= '0;
      half_r      <= HALF_RST;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        running_r <= running_nxt;
        pulse_r   <= pulse_nxt;
        step_r    <= step_nxt;
        length_r  <= length_nxt;
        half_r    <= half_nxt;
        phase_r   <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: rtl/stpr_checker.sv
// ----------------------------------------------------------------------------
// stpr_checker
// Port-level checks on the step pulser, bound to the top level.
// ----------------------------------------------------------------------------
module stpr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input stpr_pkg::out_word_t out_word
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.move_done |-> !out_word.busy_res && !out_word.step_level)
    else $error("move done while still busy or pin high");

  a_pin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.step_level |-> out_word.busy_res)
    else $error("step pin high outside a move");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind stepper_trapezoid_ramp_pulser stpr_checker u_stpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
